// File: design/sfr_pkg.sv
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 13;
    localparam int MAX_PAYLOAD_DEF = 4096;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_MASK  = 8'h20;
    localparam logic [BYTE_W-1:0] CTRL_I0   = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_I1   = 8'h80;
    localparam logic [BYTE_W-1:0] RR_BASE   = 8'hAA;
    localparam logic [BYTE_W-1:0] REJ_BASE  = 8'h54;
    localparam logic [BYTE_W-1:0] ADDR_RST  = 8'h03;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_CTRL,
        PH_BCC1,
        PH_DATA,
        PH_ESC
    } t_phase;

    typedef enum logic [2:0] {
        ST_ACCEPTED,
        ST_DUPLICATE,
        ST_REJECTED,
        ST_DUP_BAD,
        ST_TOO_LONG
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic              valid;
        logic              is_end;
        logic [BYTE_W-1:0] payload_byte;
        t_status           frame_status;
        logic [BYTE_W-1:0] reply_control;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

endpackage

// File: design/sfr_if.sv
interface sfr_rx_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] address_byte;
    modport source (output valid, output address_byte, input ready);
    modport sink (input valid, input address_byte, output ready);
endinterface

interface sfr_res_if;
    import sfr_pkg::*;
    logic              valid;
    logic              ready;
    logic              is_end;
    logic [BYTE_W-1:0] payload_byte;
    logic [2:0]        frame_status;
    logic [BYTE_W-1:0] reply_control;
    logic [LEN_W-1:0]  payload_length;
    modport source (output valid, output is_end, output payload_byte,
                    output frame_status, output reply_control,
                    output payload_length, input ready);
    modport sink (input valid, input is_end, input payload_byte,
                  input frame_status, input reply_control,
                  input payload_length, output ready);
endinterface

// File: design/sfr_in_reg.sv
module sfr_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [sfr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                      i_advance,
    output logic                      o_ready,
    output sfr_pkg::t_rx_item         o_item
);
    import sfr_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

// File: design/sfr_deframer.sv
module sfr_deframer #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfr_pkg::t_rx_item          i_item,
    input  logic                       i_cfg_valid,
    input  logic [sfr_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                       i_out_ready,
    output logic                       o_advance,
    output sfr_pkg::t_result           o_res
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_addr;
    logic              r_exp_seq, n_exp_seq;
    logic              r_frame_seq, n_frame_seq;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_held_valid, n_held_valid;
    logic [BYTE_W-1:0] r_check, n_check;
    logic [CNT_W-1:0]  r_count, n_count;
    t_result           r_out, n_out;

    logic              fire;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] bcc1;
    logic              is_flag;
    logic              ctrl_ok;
    logic              take;
    logic              too_long;
    logic              good;
    logic              seq_match;

    assign o_advance = !r_out.valid || i_out_ready;
    assign fire      = i_item.valid && o_advance;
    assign b         = i_item.rx_byte;
    assign is_flag   = (b == FLAG_BYTE);
    assign ctrl_ok   = (b == CTRL_I0) || (b == CTRL_I1);
    assign bcc1      = r_addr ^ {r_frame_seq, {(BYTE_W-1){1'b0}}};
    assign data_byte = (r_phase == PH_ESC) ? (b ^ ESC_MASK) : b;
    assign take      = (r_phase == PH_ESC) ||
                       ((r_phase == PH_DATA) && !is_flag && (b != ESC_BYTE));
    assign too_long  = take && r_held_valid && (r_count == CNT_W'(MAX_PAYLOAD));
    assign good      = (r_check == r_held);
    assign seq_match = (r_frame_seq == r_exp_seq);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (is_flag) begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (b == r_addr) begin
                    n_phase = PH_CTRL;
                end else if (!is_flag) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (ctrl_ok) begin
                    n_phase = PH_BCC1;
                end else if (is_flag) begin
                    n_phase = PH_ADDR;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BCC1: begin
                if (b == bcc1) begin
                    n_phase = PH_DATA;
                end else if (is_flag) begin
                    n_phase = PH_ADDR;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (b == ESC_BYTE) begin
                    n_phase = PH_ESC;
                end else if (is_flag || too_long) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_ESC: begin
                n_phase = too_long ? PH_HUNT : PH_DATA;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        n_exp_seq    = r_exp_seq;
        n_frame_seq  = r_frame_seq;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_check      = r_check;
        n_count      = r_count;
        n_out        = '0;
        case (r_phase)
            PH_CTRL: begin
                if (ctrl_ok) begin
                    n_frame_seq = b[BYTE_W-1];
                end
            end
            PH_BCC1: begin
                if (b == bcc1) begin
                    n_held_valid = 1'b0;
                    n_held       = '0;
                    n_check      = '0;
                    n_count      = '0;
                end
            end
            PH_DATA, PH_ESC: begin
                if (take) begin
                    if (too_long) begin
                        n_held_valid         = 1'b0;
                        n_out.valid          = 1'b1;
                        n_out.is_end         = 1'b1;
                        n_out.frame_status   = ST_TOO_LONG;
                        n_out.payload_length = LEN_W'(r_count);
                    end else begin
                        if (r_held_valid) begin
                            n_out.valid        = 1'b1;
                            n_out.payload_byte = r_held;
                            n_check            = r_check ^ r_held;
                            n_count            = r_count + 1'b1;
                        end
                        n_held       = data_byte;
                        n_held_valid = 1'b1;
                    end
                end else if (is_flag && r_held_valid) begin
                    n_held_valid         = 1'b0;
                    n_out.valid          = 1'b1;
                    n_out.is_end         = 1'b1;
                    n_out.payload_length = LEN_W'(r_count);
                    if (good && seq_match) begin
                        n_exp_seq           = !r_exp_seq;
                        n_out.frame_status  = ST_ACCEPTED;
                        n_out.reply_control = RR_BASE | {{(BYTE_W-1){1'b0}}, !r_exp_seq};
                    end else if (good) begin
                        n_out.frame_status  = ST_DUPLICATE;
                        n_out.reply_control = RR_BASE | {{(BYTE_W-1){1'b0}}, r_exp_seq};
                    end else if (seq_match) begin
                        n_out.frame_status  = ST_REJECTED;
                        n_out.reply_control = REJ_BASE | {{(BYTE_W-1){1'b0}}, r_frame_seq};
                    end else begin
                        n_out.frame_status  = ST_DUP_BAD;
                        n_out.reply_control = RR_BASE | {{(BYTE_W-1){1'b0}}, r_exp_seq};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_addr       <= ADDR_RST;
            r_exp_seq    <= 1'b0;
            r_frame_seq  <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_check      <= '0;
            r_count      <= '0;
            r_out.valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_addr <= i_cfg_data;
            end
            if (fire) begin
                r_phase      <= n_phase;
                r_exp_seq    <= n_exp_seq;
                r_frame_seq  <= n_frame_seq;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_check      <= n_check;
                r_count      <= n_count;
                r_out        <= n_out;
            end else if (i_out_ready) begin
                r_out.valid <= 1'b0;
            end
        end
    end

    assign o_res = r_out;

endmodule

// File: design/stuffed_frame_receiver_arq_core.sv
// Throughput: one received byte per cycle; ready stays high unless results back up.
// Each byte passes an input register, then one state update into the result register.
// Reset is synchronous and active low: the hunt for a flag restarts, the expected
// sequence bit clears and the address register returns to 0x03.
module stuffed_frame_receiver_arq_core #(
    parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sfr_rx_if.sink   i_rx,
    sfr_cfg_if.sink  i_cfg,
    sfr_res_if.source o_res
);
    import sfr_pkg::*;

    t_rx_item rx_item;
    t_result  res;
    logic     advance;

    sfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.rx_byte),
        .i_advance (advance),
        .o_ready   (i_rx.ready),
        .o_item    (rx_item)
    );

    sfr_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (rx_item),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.address_byte),
        .i_out_ready (o_res.ready),
        .o_advance   (advance),
        .o_res       (res)
    );

    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = res.valid;
    assign o_res.is_end         = res.is_end;
    assign o_res.payload_byte   = res.payload_byte;
    assign o_res.frame_status   = res.frame_status;
    assign o_res.reply_control  = res.reply_control;
    assign o_res.payload_length = res.payload_length;

endmodule

// File: design/sfr_checker.sv
module sfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic                       i_is_end,
    input logic [sfr_pkg::BYTE_W-1:0] i_payload_byte,
    input logic [2:0]                 i_frame_status,
    input logic [sfr_pkg::BYTE_W-1:0] i_reply_control,
    input logic [sfr_pkg::LEN_W-1:0]  i_payload_length
);
    import sfr_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_is_end) &&
        $stable(i_payload_byte) && $stable(i_frame_status) &&
        $stable(i_reply_control) && $stable(i_payload_length))
        else $error("stalled result changed");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_is_end |->
        (i_frame_status == 3'(ST_ACCEPTED)) && (i_reply_control == '0) &&
        (i_payload_length == '0))
        else $error("payload item carries status fields");

    a_reply_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_is_end |->
        ((i_frame_status == 3'(ST_TOO_LONG)) == (i_reply_control == '0)) &&
        (i_payload_byte == '0))
        else $error("reply control does not match status");

endmodule

bind stuffed_frame_receiver_arq_core sfr_checker u_sfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_is_end         (o_res.is_end),
    .i_payload_byte   (o_res.payload_byte),
    .i_frame_status   (o_res.frame_status),
    .i_reply_control  (o_res.reply_control),
    .i_payload_length (o_res.payload_length)
);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import sfr_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic              is_end;
        logic [BYTE_W-1:0] payload_byte;
        t_status           frame_status;
        logic [BYTE_W-1:0] reply_control;
        logic [LEN_W-1:0]  payload_length;
    } t_deframed;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sfr_rx_if  rx();
    sfr_cfg_if cfg();
    sfr_res_if res();

    stuffed_frame_receiver_arq_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Line side stimulus and bookkeeping.
    logic [BYTE_W-1:0] line_q[$];
    int unsigned       line_bytes_queued = 0;
    int unsigned       line_bytes_taken = 0;
    int unsigned       frame_bytes = 0;
    logic [BYTE_W-1:0] line_addr = ADDR_RST;
    logic              calm = 1'b0;
    int unsigned       addr_writes = 0;

    // Predicted receiver state.
    t_phase            rx_phase;
    logic              seq_expected;
    logic              seq_frame;
    logic [BYTE_W-1:0] held_data;
    logic              held_full;
    logic [BYTE_W-1:0] data_xor;
    int unsigned       data_count;
    logic [BYTE_W-1:0] station_addr;
    t_deframed         deframed_q[$];

    int unsigned mismatches = 0;
    int unsigned payloads_seen = 0;
    int unsigned status_seen[5];
    int unsigned cycle_count = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_line(input logic [BYTE_W-1:0] b);
        line_q.push_back(b);
        line_bytes_queued++;
    endfunction

    function automatic void push_list(input logic [BYTE_W-1:0] bl[$]);
        foreach (bl[i]) push_line(bl[i]);
    endfunction

    function automatic void push_data(input logic [BYTE_W-1:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE || $urandom_range(0, 15) == 0) begin
            push_line(ESC_BYTE);
            push_line(d ^ ESC_MASK);
        end else begin
            push_line(d);
        end
    endfunction

    function automatic void push_frame(input int n_data, input logic seq,
                                       input logic corrupt, input logic opening);
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] bcc2;
        logic [BYTE_W-1:0] ctrl;
        ctrl = seq ? CTRL_I1 : CTRL_I0;
        bcc2 = '0;
        if (opening) begin
            push_line(FLAG_BYTE);
            if ($urandom_range(0, 4) == 0) push_line(FLAG_BYTE);
        end
        push_line(line_addr);
        push_line(ctrl);
        push_line(line_addr ^ ctrl);
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                d = ($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE)
                    ^ ($urandom_range(0, 1) ? ESC_MASK : 8'h00);
            end else begin
                d = 8'($urandom);
            end
            bcc2 ^= d;
            push_data(d);
        end
        if (corrupt) bcc2 ^= 8'($urandom_range(1, 255));
        push_data(bcc2);
        push_line(FLAG_BYTE);
        frame_bytes += n_data + 5;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(13, 60);
        return $urandom_range(0, 12);
    endfunction

    function automatic void push_broken_header();
        logic [BYTE_W-1:0] hdr[4];
        logic              seq;
        int unsigned       cut;
        seq = $urandom_range(0, 1);
        hdr[0] = FLAG_BYTE;
        hdr[1] = line_addr;
        hdr[2] = seq ? CTRL_I1 : CTRL_I0;
        hdr[3] = line_addr ^ hdr[2];
        cut = $urandom_range(1, 3);
        hdr[cut] = $urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom);
        for (int i = 0; i <= int'(cut); i++) push_line(hdr[i]);
        frame_bytes += cut + 1;
        if (hdr[cut] == FLAG_BYTE) push_frame(pick_len(), seq, 1'b0, 1'b0);
    endfunction

    function automatic void expect_result(input logic is_end, input logic [BYTE_W-1:0] d,
                                          input t_status st, input logic [BYTE_W-1:0] reply);
        t_deframed r;
        r.is_end         = is_end;
        r.payload_byte   = d;
        r.frame_status   = st;
        r.reply_control  = reply;
        r.payload_length = is_end ? LEN_W'(data_count) : '0;
        deframed_q.push_back(r);
    endfunction

    function automatic void take_payload(input logic [BYTE_W-1:0] d);
        if (held_full) begin
            if (data_count >= MAX_PAYLOAD) begin
                expect_result(1'b1, 8'h00, ST_TOO_LONG, 8'h00);
                rx_phase  = PH_HUNT;
                held_full = 1'b0;
                return;
            end
            expect_result(1'b0, held_data, ST_ACCEPTED, 8'h00);
            data_xor ^= held_data;
            data_count++;
        end
        held_data = d;
        held_full = 1'b1;
    endfunction

    function automatic void close_frame();
        logic good;
        logic match;
        rx_phase = PH_HUNT;
        if (!held_full) return;
        held_full = 1'b0;
        good  = (data_xor == held_data);
        match = (seq_frame == seq_expected);
        if (good && match) begin
            seq_expected = ~seq_expected;
            expect_result(1'b1, 8'h00, ST_ACCEPTED, RR_BASE | {7'd0, seq_expected});
        end else if (good) begin
            expect_result(1'b1, 8'h00, ST_DUPLICATE, RR_BASE | {7'd0, seq_expected});
        end else if (match) begin
            expect_result(1'b1, 8'h00, ST_REJECTED, REJ_BASE | {7'd0, seq_frame});
        end else begin
            expect_result(1'b1, 8'h00, ST_DUP_BAD, RR_BASE | {7'd0, seq_expected});
        end
    endfunction

    function automatic void absorb_line_byte(input logic [BYTE_W-1:0] b);
        case (rx_phase)
            PH_HUNT: begin
                if (b == FLAG_BYTE) rx_phase = PH_ADDR;
            end
            PH_ADDR: begin
                if (b == station_addr) rx_phase = PH_CTRL;
                else if (b != FLAG_BYTE) rx_phase = PH_HUNT;
            end
            PH_CTRL: begin
                if (b == CTRL_I0 || b == CTRL_I1) begin
                    seq_frame = b[7];
                    rx_phase  = PH_BCC1;
                end else if (b == FLAG_BYTE) begin
                    rx_phase = PH_ADDR;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_BCC1: begin
                if (b == (station_addr ^ {seq_frame, 7'd0})) begin
                    rx_phase   = PH_DATA;
                    held_full  = 1'b0;
                    held_data  = '0;
                    data_xor   = '0;
                    data_count = 0;
                end else if (b == FLAG_BYTE) begin
                    rx_phase = PH_ADDR;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (b == ESC_BYTE) rx_phase = PH_ESC;
                else if (b == FLAG_BYTE) close_frame();
                else take_payload(b);
            end
            PH_ESC: begin
                rx_phase = PH_DATA;
                take_payload(b ^ ESC_MASK);
            end
            default: begin
                rx_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Line byte driver.
    int unsigned rx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx.valid <= 1'b0;
            rx_gap = 0;
        end else if (!rx.valid || rx.ready) begin
            if (rx_gap > 0) begin
                rx_gap--;
                rx.valid <= 1'b0;
            end else if (line_q.size() != 0) begin
                rx.rx_byte <= line_q.pop_front();
                rx.valid <= 1'b1;
                rx_gap = pick_gap();
            end else begin
                rx.valid <= 1'b0;
            end
        end
    end

    // Predictor: follows accepted line bytes and address writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_phase     = PH_HUNT;
            seq_expected = 1'b0;
            seq_frame    = 1'b0;
            held_data    = '0;
            held_full    = 1'b0;
            data_xor     = '0;
            data_count   = 0;
            station_addr = ADDR_RST;
        end else begin
            if (cfg.valid && cfg.ready) station_addr = cfg.address_byte;
            if (rx.valid && rx.ready) begin
                absorb_line_byte(rx.rx_byte);
                line_bytes_taken++;
            end
        end
    end

    // Result monitor with random back-pressure.
    int unsigned res_stall = 0;

    always @(posedge i_clk) begin
        t_deframed want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (res.valid && res.ready) begin
                if (res.is_end) begin
                    if (res.frame_status <= ST_TOO_LONG) status_seen[res.frame_status]++;
                end else begin
                    payloads_seen++;
                end
                if (deframed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected: end=%0d data=%02h status=%0d reply=%02h len=%0d",
                                 res.is_end, res.payload_byte, res.frame_status,
                                 res.reply_control, res.payload_length);
                    end
                end else begin
                    want = deframed_q.pop_front();
                    if (res.is_end !== want.is_end || res.payload_byte !== want.payload_byte
                        || res.frame_status !== want.frame_status
                        || res.reply_control !== want.reply_control
                        || res.payload_length !== want.payload_length) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t:", $realtime);
                            $display("    expected end=%0d data=%02h status=%0d reply=%02h len=%0d",
                                     want.is_end, want.payload_byte, want.frame_status,
                                     want.reply_control, want.payload_length);
                            $display("    got end=%0d data=%02h status=%0d reply=%02h len=%0d",
                                     res.is_end, res.payload_byte, res.frame_status,
                                     res.reply_control, res.payload_length);
                        end
                    end
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
                res_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[stuffed_frame_receiver_arq_core] ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (line_bytes_taken != line_bytes_queued || deframed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [BYTE_W-1:0] a);
        cfg.address_byte <= a;
        cfg.valid <= 1'b1;
        do @(posedge i_clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        line_addr = a;
        addr_writes++;
    endtask

    initial begin
        logic [BYTE_W-1:0] addr_plan[5];
        int unsigned       target;
        int unsigned       pick;
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        cfg.valid = 1'b0;
        cfg.address_byte = '0;
        res.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Accepted frame with an escaped flag, opened by a repeated flag.
        push_list('{FLAG_BYTE, FLAG_BYTE, ADDR_RST, CTRL_I0, ADDR_RST ^ CTRL_I0,
                    ESC_BYTE, FLAG_BYTE ^ ESC_MASK, ESC_BYTE, FLAG_BYTE ^ ESC_MASK,
                    FLAG_BYTE});
        // Empty frame.
        push_list('{FLAG_BYTE, ADDR_RST, CTRL_I1, ADDR_RST ^ CTRL_I1, FLAG_BYTE});
        // Flag in the control field, then a duplicate.
        push_list('{FLAG_BYTE, ADDR_RST, FLAG_BYTE, ADDR_RST, CTRL_I0, ADDR_RST ^ CTRL_I0,
                    8'h00, FLAG_BYTE});
        // Bad check on the expected sequence, then on the other one.
        push_list('{FLAG_BYTE, ADDR_RST, CTRL_I1, ADDR_RST ^ CTRL_I1, 8'hFF, 8'h01,
                    FLAG_BYTE});
        push_list('{FLAG_BYTE, ADDR_RST, CTRL_I0, ADDR_RST ^ CTRL_I0, 8'h01, FLAG_BYTE});

        addr_plan = '{8'h00, 8'hFF, 8'h7E, 8'($urandom), ESC_BYTE};
        foreach (addr_plan[i]) begin
            wait_idle();
            write_address(addr_plan[i]);
            calm <= (i == 2);
            target = frame_bytes + 70;
            while (frame_bytes < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    push_frame(pick_len(), $urandom_range(0, 1), $urandom_range(0, 4) == 0, 1'b1);
                end else if (pick < 90) begin
                    push_broken_header();
                end else begin
                    repeat ($urandom_range(1, 4)) push_line(8'($urandom));
                end
            end
        end
        wait_idle();

        $display("%0d line bytes, %0d payload results, %0d address writes", line_bytes_taken,
                 payloads_seen, addr_writes);
        $display("frame ends: accepted %0d, duplicate %0d, rejected %0d, dup bad %0d, long %0d",
                 status_seen[ST_ACCEPTED], status_seen[ST_DUPLICATE], status_seen[ST_REJECTED],
                 status_seen[ST_DUP_BAD], status_seen[ST_TOO_LONG]);
        if (mismatches == 0) begin
            $display("[stuffed_frame_receiver_arq_core] OK");
        end else begin
            $display("[stuffed_frame_receiver_arq_core] ERROR");
        end
        $finish;
    end

endmodule
